// File: src/apr_pkg.sv
// apr_pkg: shared constants and types for the aging page replacement block
// widths of the page, age and frame fields, controller state codes and the
// command/status structs between controller and datapath; no dependencies
package apr_pkg;

  localparam int unsigned FRAMES_DEF = 16;
  localparam int unsigned PAGE_W     = 16;
  localparam int unsigned AGE_W      = 16;
  localparam int unsigned FRAME_W    = 4;
  localparam int unsigned CFG_W      = 5;

  localparam logic [AGE_W-1:0] AGE_TOP   = 16'h8000;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd10;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } apr_state_e;

  typedef struct packed {
    logic load;    // nonzero reference taken, prepare a scan
    logic zero;    // reserved page zero taken, answer at once
    logic scan;    // walk the frames
    logic commit;  // update the chosen frame and register the result
  } apr_cmd_t;

  typedef struct packed {
    logic page_zero;  // incoming page is the reserved value
    logic scan_last;  // last frame is being examined this cycle
  } apr_status_t;

endpackage

// File: src/apr_ctrl.sv
// apr_ctrl: sequencer for one page reference (idle, frame scan, commit)
// depends on apr_pkg for the state codes and the command/status structs
module apr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  apr_pkg::apr_status_t status_i,
  output apr_pkg::apr_cmd_t    cmd_o,
  output logic                 busy
);
  import apr_pkg::*;

  apr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (status_i.page_zero) begin
            cmd_o.zero = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// File: src/apr_datapath.sv
// apr_datapath: frame page and age memories, scan pipeline, selection and results
// depends on apr_pkg; driven by apr_ctrl through apr_cmd_t
module apr_datapath #(
  parameter int unsigned FRAMES = apr_pkg::FRAMES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  apr_pkg::apr_cmd_t           cmd_i,
  output apr_pkg::apr_status_t        status_o,
  input  logic [apr_pkg::PAGE_W-1:0]  page_i,
  input  logic                        cfg_we_i,
  input  logic [apr_pkg::CFG_W-1:0]   cfg_wdata_i,
  output logic                        done_o,
  output logic                        hit_o,
  output logic [apr_pkg::FRAME_W-1:0] frame_o,
  output logic                        evicted_valid_o,
  output logic [apr_pkg::PAGE_W-1:0]  evicted_page_o
);
  import apr_pkg::*;

  localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CNT_W = $clog2(FRAMES + 1);

  // memories, entries not yet written read as zero through the valid bits
  logic [PAGE_W-1:0] page_mem [FRAMES];
  logic [AGE_W-1:0]  age_mem  [FRAMES];
  logic [FRAMES-1:0] page_vld_q;
  logic [FRAMES-1:0] age_vld_q;

  logic [CFG_W-1:0]  cfg_q;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  n_q;
  logic [PAGE_W-1:0] pg_q;

  logic [CNT_W-1:0]  rd_addr_q;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  proc_idx_q;
  logic [PAGE_W-1:0] rd_page_q;
  logic [AGE_W-1:0]  rd_age_q;
  logic              rd_page_ok_q;
  logic              rd_age_ok_q;

  logic              found_q;
  logic [IDX_W-1:0]  match_idx_q;
  logic [AGE_W-1:0]  match_age_q;
  logic              empty_q;
  logic [IDX_W-1:0]  empty_idx_q;
  logic [AGE_W-1:0]  best_q;
  logic [IDX_W-1:0]  min_idx_q;
  logic [PAGE_W-1:0] min_page_q;

  logic              issue;
  logic              proc;
  logic [PAGE_W-1:0] cur_page;
  logic [AGE_W-1:0]  cur_age;
  logic [IDX_W-1:0]  slot;

  logic              age_we;
  logic [IDX_W-1:0]  age_waddr;
  logic [AGE_W-1:0]  age_wdata;
  logic              page_we;

  logic              done_q;
  logic              hit_q;
  logic [IDX_W-1:0]  frame_q;
  logic              ev_vld_q;
  logic [PAGE_W-1:0] ev_page_q;

  // effective frame count: zero acts as one, clamp at the frame count
  always_comb begin
    if (cfg_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(cfg_q) > 32'(FRAMES)) begin
      n_eff = CNT_W'(FRAMES);
    end else begin
      n_eff = CNT_W'(cfg_q);
    end
  end

  assign issue    = cmd_i.scan && (rd_addr_q != n_q);
  assign proc     = cmd_i.scan && rd_vld_q;
  assign cur_page = rd_page_ok_q ? rd_page_q : '0;
  assign cur_age  = (rd_age_ok_q ? rd_age_q : '0) >> 1;

  assign status_o.page_zero = (page_i == '0);
  assign status_o.scan_last = rd_vld_q && (rd_addr_q == n_q);

  always_comb begin
    if (found_q) begin
      slot = match_idx_q;
    end else if (empty_q) begin
      slot = empty_idx_q;
    end else begin
      slot = min_idx_q;
    end
  end

  // age port: shifted value during the scan, refreshed counter at commit
  assign age_we    = proc || cmd_i.commit;
  assign age_waddr = cmd_i.commit ? slot : proc_idx_q;
  always_comb begin
    if (!cmd_i.commit) begin
      age_wdata = cur_age;
    end else if (found_q) begin
      age_wdata = match_age_q | AGE_TOP;
    end else begin
      age_wdata = AGE_TOP;
    end
  end
  assign page_we = cmd_i.commit && !found_q;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_page_q    <= page_mem[rd_addr_q[IDX_W-1:0]];
      rd_age_q     <= age_mem[rd_addr_q[IDX_W-1:0]];
      rd_page_ok_q <= page_vld_q[rd_addr_q[IDX_W-1:0]];
      rd_age_ok_q  <= age_vld_q[rd_addr_q[IDX_W-1:0]];
      proc_idx_q   <= rd_addr_q[IDX_W-1:0];
    end
    if (age_we) begin
      age_mem[age_waddr] <= age_wdata;
    end
    if (page_we) begin
      page_mem[slot] <= pg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_vld_q <= '0;
      age_vld_q  <= '0;
      cfg_q      <= CFG_RESET;
      rd_addr_q  <= '0;
      rd_vld_q   <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (age_we) begin
        age_vld_q[age_waddr] <= 1'b1;
      end
      if (page_we) begin
        page_vld_q[slot] <= 1'b1;
      end
      if (cmd_i.load) begin
        rd_addr_q <= '0;
      end else if (issue) begin
        rd_addr_q <= rd_addr_q + CNT_W'(1);
      end
      rd_vld_q <= issue;
      done_q   <= cmd_i.zero || cmd_i.commit;
    end
  end

  // scan bookkeeping: first match, first empty frame, lowest shifted age
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pg_q    <= page_i;
      n_q     <= n_eff;
      found_q <= 1'b0;
      empty_q <= 1'b0;
    end else if (proc) begin
      if (!found_q && (cur_page == pg_q)) begin
        found_q     <= 1'b1;
        match_idx_q <= proc_idx_q;
        match_age_q <= cur_age;
      end
      if (!empty_q && (cur_page == '0)) begin
        empty_q     <= 1'b1;
        empty_idx_q <= proc_idx_q;
      end
      if ((proc_idx_q == '0) || (cur_age < best_q)) begin
        best_q     <= cur_age;
        min_idx_q  <= proc_idx_q;
        min_page_q <= cur_page;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.zero) begin
      hit_q     <= 1'b0;
      frame_q   <= '0;
      ev_vld_q  <= 1'b0;
      ev_page_q <= '0;
    end else if (cmd_i.commit) begin
      hit_q     <= found_q;
      frame_q   <= slot;
      ev_vld_q  <= !found_q && !empty_q;
      ev_page_q <= (!found_q && !empty_q) ? min_page_q : '0;
    end
  end

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign frame_o         = FRAME_W'(frame_q);
  assign evicted_valid_o = ev_vld_q;
  assign evicted_page_o  = ev_page_q;

endmodule

// File: src/aging_page_replacement.sv
// aging_page_replacement: top level of the aging page replacement block
// joins apr_ctrl and apr_datapath; depends on apr_pkg
//
//   channel    ports                                         transfer when
//   reference  start, busy, page_i                           start && !busy
//   result     done_o, hit_o, frame_o, evicted_valid_o,      done_o
//              evicted_page_o
//   config     cfg_we_i, cfg_wdata_i (frames_in_use)         cfg_we_i
//
// a reference to a nonzero page keeps busy high while the frames in use, as many
// as the effective frame count, are scanned one per cycle through the single read
// port of the page and age memories, and then through the commit state
// the result strobe comes in the same cycle as busy falls; page zero is answered
// in the next cycle. the receiver cannot stall, so results never back up
// reset clears the memories through per-frame valid bits, no clearing pass
module aging_page_replacement #(
  parameter int unsigned FRAMES = apr_pkg::FRAMES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [apr_pkg::PAGE_W-1:0]  page_i,
  input  logic                        cfg_we_i,
  input  logic [apr_pkg::CFG_W-1:0]   cfg_wdata_i,
  output logic                        done_o,
  output logic                        hit_o,
  output logic [apr_pkg::FRAME_W-1:0] frame_o,
  output logic                        evicted_valid_o,
  output logic [apr_pkg::PAGE_W-1:0]  evicted_page_o
);
  import apr_pkg::*;

  apr_cmd_t    cmd;
  apr_status_t status;

  apr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  apr_datapath #(
    .FRAMES (FRAMES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .page_i          (page_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .hit_o           (hit_o),
    .frame_o         (frame_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o)
  );

  // page zero is answered in the next cycle with an all-zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (page_i == '0)) |=>
      (done_o && !hit_o && !evicted_valid_o && (frame_o == '0)))
    else $error("page zero reference not answered at once");

  // a result always follows the end of a reference, never overlaps a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // a hit never evicts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(hit_o && evicted_valid_o))
    else $error("hit with eviction");

  // no eviction means no evicted page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !evicted_valid_o) |-> (evicted_page_o == '0))
    else $error("evicted page without eviction");

endmodule

// File: verif/aging_page_replacement_tb.sv
// aging_page_replacement_tb: self-checking testbench for the aging page replacement block
// drives page references and frame-count writes, predicts every result in-bench
// and compares it field by field; depends on apr_pkg and aging_page_replacement
module aging_page_replacement_tb;
  import apr_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 24;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
  } page_outcome_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               req_start   = 1'b0;
  logic [PAGE_W-1:0]  req_page    = '0;
  logic               cfg_we      = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata   = '0;
  logic               busy;
  logic               done_o;
  logic               hit_o;
  logic [FRAME_W-1:0] frame_o;
  logic               evicted_valid_o;
  logic [PAGE_W-1:0]  evicted_page_o;

  // predictor state
  logic [PAGE_W-1:0]  resident_page [FRAMES_DEF];
  logic [AGE_W-1:0]   age_count     [FRAMES_DEF];
  logic [CFG_W-1:0]   frames_cfg;

  logic [PAGE_W-1:0]  pending_pages [$];
  page_outcome_t      expected_outcomes [$];
  int unsigned        sender_idle_pct = 0;
  int unsigned        mismatches = 0;
  int unsigned        stall_cycles = 0;
  bit                 ref_taken = 1'b0;

  aging_page_replacement i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (req_start),
    .busy            (busy),
    .page_i          (req_page),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .done_o          (done_o),
    .hit_o           (hit_o),
    .frame_o         (frame_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic page_outcome_t reference_page(input logic [PAGE_W-1:0] pg);
    page_outcome_t    res;
    int unsigned      n;
    int unsigned      slot;
    bit               found;
    bit               empty;
    logic [AGE_W-1:0] best;
    res   = '0;
    found = 1'b0;
    empty = 1'b0;
    slot  = 0;
    if (pg == '0) return res;
    n = frames_cfg;
    if (n < 1) n = 1;
    if (n > FRAMES_DEF) n = FRAMES_DEF;
    for (int i = 0; i < n; i++) begin
      if (!found && resident_page[i] == pg) begin
        found = 1'b1;
        slot  = i;
      end
    end
    for (int i = 0; i < n; i++) age_count[i] = age_count[i] >> 1;
    if (found) begin
      age_count[slot] = age_count[slot] | AGE_TOP;
      res.hit = 1'b1;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!empty && resident_page[i] == '0) begin
          empty = 1'b1;
          slot  = i;
        end
      end
      if (!empty) begin
        // smallest counter, lowest index on ties
        best = age_count[0];
        slot = 0;
        for (int i = 1; i < n; i++) begin
          if (age_count[i] < best) begin
            best = age_count[i];
            slot = i;
          end
        end
        res.evicted_valid = 1'b1;
        res.evicted_page  = resident_page[slot];
      end
      resident_page[slot] = pg;
      age_count[slot]     = AGE_TOP;
    end
    res.frame = slot[FRAME_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // driver: holds a reference until its transfer, then maybe idles
  always @(negedge clk_i) begin
    if (!req_start || ref_taken) begin
      if (pending_pages.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        req_page  <= pending_pages.pop_front();
        req_start <= 1'b1;
      end else begin
        req_start <= 1'b0;
      end
    end
  end

  // monitor: check results first, then predict the reference taken at this edge
  always @(posedge clk_i) begin
    page_outcome_t exp_res;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("result strobe with nothing expected");
        end else begin
          exp_res = expected_outcomes.pop_front();
          if (hit_o !== exp_res.hit)
            report_mismatch($sformatf("hit %b, expected %b", hit_o, exp_res.hit));
          if (frame_o !== exp_res.frame)
            report_mismatch($sformatf("frame %0d, expected %0d", frame_o, exp_res.frame));
          if (evicted_valid_o !== exp_res.evicted_valid)
            report_mismatch($sformatf("evicted_valid %b, expected %b",
                                      evicted_valid_o, exp_res.evicted_valid));
          if (evicted_page_o !== exp_res.evicted_page)
            report_mismatch($sformatf("evicted_page %h, expected %h",
                                      evicted_page_o, exp_res.evicted_page));
        end
      end
      ref_taken = req_start && !busy;
      if (ref_taken) expected_outcomes.push_back(reference_page(req_page));
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_start && !busy) || done_o) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
          $display("FAIL aging_page_replacement");
          $finish;
        end
      end
    end
  end

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_pages.size() != 0 || req_start || expected_outcomes.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // only called while the block is idle
  task automatic write_frame_count(input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we     <= 1'b1;
    cfg_wdata  <= value;
    frames_cfg  = value;
    @(negedge clk_i);
    cfg_we     <= 1'b0;
  endtask

  task automatic queue_random_refs(input int unsigned count);
    logic [PAGE_W-1:0] pool [24];
    int unsigned       pool_size;
    int unsigned       r;
    logic [31:0]       rnd;
    pool_size = $urandom_range(24, 2);
    for (int i = 0; i < 24; i++) pool[i] = PAGE_W'($urandom_range(16'hFFFF, 1));
    for (int unsigned k = 0; k < count; k++) begin
      r   = $urandom_range(99);
      rnd = $urandom();
      if (r < 5)       pending_pages.push_back('0);
      else if (r < 75) pending_pages.push_back(pool[$urandom_range(pool_size - 1)]);
      else             pending_pages.push_back(rnd[PAGE_W-1:0]);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] phase_cfg [14];
    for (int i = 0; i < FRAMES_DEF; i++) begin
      resident_page[i] = '0;
      age_count[i]     = '0;
    end
    frames_cfg = CFG_RESET;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: fill from empty at the reset count, reserved zero, hit, eviction
    sender_idle_pct = 7;
    for (int p = 1; p <= 10; p++) pending_pages.push_back(PAGE_W'(p));
    pending_pages.push_back('0);
    pending_pages.push_back(16'h0003);
    pending_pages.push_back(16'hFFFF);
    pending_pages.push_back(16'hFFFF);
    pending_pages.push_back('0);
    wait_drained();
    // single frame, then zero count acting as one
    write_frame_count(CFG_W'(1));
    pending_pages.push_back(16'h5555);
    pending_pages.push_back(16'hAAAA);
    wait_drained();
    write_frame_count('0);
    pending_pages.push_back(16'h5555);
    pending_pages.push_back(16'hAAAA);
    wait_drained();
    // count above the frame total acts as all frames; old contents reappear
    write_frame_count('1);
    pending_pages.push_back(16'h0007);
    pending_pages.push_back(16'h1234);
    pending_pages.push_back(16'h8001);
    pending_pages.push_back(16'h0001);
    wait_drained();

    phase_cfg = '{5'd16, 5'd1, 5'd4, 5'd17, 5'd0, 5'd2, 5'd31, 5'd10,
                  5'd15, 5'd8, 5'd16, 5'd3, 5'd12, 5'd16};
    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 5 || ph == 10) phase_cfg[ph] = CFG_W'($urandom_range(31, 0));
      sender_idle_pct = (ph < 5) ? 7 : (ph < 10) ? 73 : 0;
      write_frame_count(phase_cfg[ph]);
      queue_random_refs(36);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_outcomes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));
    if (mismatches == 0) begin
      $display("PASS aging_page_replacement");
    end else begin
      $display("FAIL aging_page_replacement");
    end
    $finish;
  end

endmodule
